// ===== rtl/core/loaq_pkg.sv =====
// Shared types and constants for the load overrun alarm qualifier.
// Depends on nothing; imported by load_overrun_alarm_qualifier.
package loaq_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Function codes of an input word
   localparam logic [1:0] FUNC_REPORT = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // Register map
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 30;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMER_THR   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARN_THR   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPD_INTVL  = 3'd4;

   // Register reset values
   localparam logic        RST_ENABLE    = 1'b1;
   localparam logic [29:0] RST_TARGET    = 30'd11609977;
   localparam logic [7:0]  RST_EMER_THR  = 8'd3;
   localparam logic [7:0]  RST_WARN_THR  = 8'd5;
   localparam logic [7:0]  RST_UPD_INTVL = 8'd64;

   // Compare levels in 8.8 percent: 95% and 80% of the period
   localparam logic [15:0] LEVEL_OVER_Q8 = 16'd24320;
   localparam logic [15:0] LEVEL_HIGH_Q8 = 16'd20480;

   localparam logic [7:0]  COUNT_MAX = 8'd255;

endpackage

// ===== rtl/core/load_overrun_alarm_qualifier.sv =====
// Load overrun alarm qualifier: top level, single module.
// Depends on loaq_pkg (state type, function codes, register map, levels).
//
// Turns buffer processing-time reports into an emergency flag and a warning
// flag. A report word (func 0) stores the measured time. A tick word (func 1)
// advances the frame divider while enabled, and runs one evaluation each time
// the divider reaches the programmed tick interval. A clear word (func 2)
// zeroes all state; func 3 only reports. Each input word returns exactly one
// result word carrying both flags and the load as floor(time*25600/target),
// unsigned 8.8 percent, saturated at 65535. The load comes out of a radix-2
// long divider that takes one numerator bit per cycle from a shift register,
// so the datapath stays one 31-bit subtract wide. The numerator has
// TIME_BITS+15 bits; each word passes through a load state, one divider step
// per numerator bit and a finish state before rsp_valid, and the next word
// is not accepted until the current one has finished. The same quotient and
// remainder settle the 95% and 80% compares exactly. A finished result sits
// in the output register while the next word is accepted; the finish cycle
// waits only if that register is still full. Configuration writes are always
// ready and should be issued only while the block is idle.
module load_overrun_alarm_qualifier #(
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_func,
   input  logic [31:0]                           req_processing_time_ns,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_emergency_active,
   output logic                                  rsp_warning_active,
   output logic [15:0]                           rsp_load_percent_q8,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [loaq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [loaq_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import loaq_pkg::*;

   // numerator = time * 100 * 256
   localparam int PW = TIME_BITS + 7;   // time * 100
   localparam int NW = TIME_BITS + 15;  // numerator width = divider steps
   localparam int CW = $clog2(NW);

   // registers
   logic        enable_ff;
   logic [29:0] target_ff;
   logic [7:0]  emer_thr_ff;
   logic [7:0]  warn_thr_ff;
   logic [7:0]  upd_intvl_ff;

   // alarm state
   logic [TIME_BITS-1:0] stored_ff, stored_in;
   logic [7:0]           frame_ff, frame_in;
   logic [7:0]           emer_cnt_ff, emer_cnt_in;
   logic [7:0]           warn_cnt_ff, warn_cnt_in;
   logic                 emer_flag_ff, emer_flag_in;
   logic                 warn_flag_ff, warn_flag_in;
   logic                 eval_ff, eval_in;

   // sequencer
   state_type state_ff, state_in;
   logic      do_accept;
   logic      do_load;
   logic      do_step;
   logic      do_finish;
   logic      out_free;
   logic      last_step;

   // divider
   logic [NW-1:0] num_ff;
   logic [29:0]   rem_ff;
   logic [15:0]   quo_ff;
   logic          sat_ff;
   logic [CW-1:0] step_ff;
   logic [PW-1:0] prod;
   logic [30:0]   trial;
   logic [30:0]   diff;
   logic          qbit;

   // result
   logic        rsp_valid_ff;
   logic        rsp_emer_ff;
   logic        rsp_warn_ff;
   logic [15:0] rsp_load_ff;
   logic [15:0] load_q8;
   logic        rem_nz;
   logic        over;
   logic        high;
   logic        warn_up;
   logic [8:0]  frame_next;

   // ---------------------------------------------------------------
   // Register port: always ready, unknown indexes are dropped
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= RST_ENABLE;
         target_ff    <= RST_TARGET;
         emer_thr_ff  <= RST_EMER_THR;
         warn_thr_ff  <= RST_WARN_THR;
         upd_intvl_ff <= RST_UPD_INTVL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_TARGET:    target_ff    <= csr_wdata[29:0];
            CSR_EMER_THR:  emer_thr_ff  <= csr_wdata[7:0];
            CSR_WARN_THR:  warn_thr_ff  <= csr_wdata[7:0];
            CSR_UPD_INTVL: upd_intvl_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: IDLE -> LOAD -> DIV (NW steps) -> FINISH -> IDLE
   // ---------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == CW'(NW - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV:    if (last_step) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      do_load   = 1'b0;
      do_step   = 1'b0;
      do_finish = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD:   do_load   = 1'b1;
         ST_DIV:    do_step   = 1'b1;
         ST_FINISH: do_finish = out_free;
         default: ;
      endcase
   end

   assign do_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------
   // Input word: report, tick, clear. Counters move at finish time,
   // once the quotient is known.
   // ---------------------------------------------------------------
   assign frame_next = {1'b0, frame_ff} + 9'd1;

   // quotient in 8.8 percent, forced to zero for a zero time (a zero
   // target would otherwise divide to all ones)
   assign load_q8 = (stored_ff == '0) ? 16'd0 : (sat_ff ? 16'hFFFF : quo_ff);
   assign rem_nz  = (rem_ff != '0);
   // time*25600 > level*target, read from quotient and remainder
   assign over = (load_q8 > LEVEL_OVER_Q8) || ((load_q8 == LEVEL_OVER_Q8) && rem_nz);
   assign high = (load_q8 > LEVEL_HIGH_Q8) || ((load_q8 == LEVEL_HIGH_Q8) && rem_nz);

   always_comb begin
      stored_in    = stored_ff;
      frame_in     = frame_ff;
      emer_cnt_in  = emer_cnt_ff;
      warn_cnt_in  = warn_cnt_ff;
      emer_flag_in = emer_flag_ff;
      warn_flag_in = warn_flag_ff;
      eval_in      = eval_ff;
      warn_up      = 1'b0;
      if (do_accept) begin
         eval_in = 1'b0;
         case (req_func)
            FUNC_REPORT: stored_in = TIME_BITS'(req_processing_time_ns);
            FUNC_TICK: begin
               if (enable_ff) begin
                  if (frame_next >= {1'b0, upd_intvl_ff}) begin
                     frame_in = 8'd0;
                     eval_in  = 1'b1;
                  end else begin
                     frame_in = frame_next[7:0];
                  end
               end
            end
            FUNC_CLEAR: begin
               stored_in    = '0;
               frame_in     = 8'd0;
               emer_cnt_in  = 8'd0;
               warn_cnt_in  = 8'd0;
               emer_flag_in = 1'b0;
               warn_flag_in = 1'b0;
            end
            default: ;
         endcase
      end else if (do_finish && eval_ff) begin
         // emergency counter first; warning sees the updated flag
         if (over) begin
            if (emer_cnt_ff != COUNT_MAX) emer_cnt_in = emer_cnt_ff + 8'd1;
            if (emer_cnt_in >= emer_thr_ff) emer_flag_in = 1'b1;
         end else begin
            if (emer_cnt_ff != 8'd0) emer_cnt_in = emer_cnt_ff - 8'd1;
            if (emer_cnt_in == 8'd0) emer_flag_in = 1'b0;
         end
         warn_up = high && !emer_flag_in;
         if (warn_up) begin
            if (warn_cnt_ff != COUNT_MAX) warn_cnt_in = warn_cnt_ff + 8'd1;
            if (warn_cnt_in >= warn_thr_ff) warn_flag_in = 1'b1;
         end else begin
            if (warn_cnt_ff != 8'd0) warn_cnt_in = warn_cnt_ff - 8'd1;
            if (warn_cnt_in == 8'd0) warn_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         frame_ff     <= 8'd0;
         emer_cnt_ff  <= 8'd0;
         warn_cnt_ff  <= 8'd0;
         emer_flag_ff <= 1'b0;
         warn_flag_ff <= 1'b0;
         eval_ff      <= 1'b0;
      end else begin
         stored_ff    <= stored_in;
         frame_ff     <= frame_in;
         emer_cnt_ff  <= emer_cnt_in;
         warn_cnt_ff  <= warn_cnt_in;
         emer_flag_ff <= emer_flag_in;
         warn_flag_ff <= warn_flag_in;
         eval_ff      <= eval_in;
      end
   end

   // ---------------------------------------------------------------
   // Bit-serial long divider: numerator shifts out MSB first into a
   // 30-bit remainder; quotient bits above bit 15 fold into sat_ff.
   // ---------------------------------------------------------------
   assign prod  = (PW'(stored_ff) << 6) + (PW'(stored_ff) << 5) + (PW'(stored_ff) << 2);
   assign trial = {rem_ff, num_ff[NW-1]};
   assign diff  = trial - {1'b0, target_ff};
   assign qbit  = (trial >= {1'b0, target_ff});

   always_ff @(posedge clock) begin
      if (do_load) begin
         num_ff  <= {prod, 8'd0};
         rem_ff  <= '0;
         quo_ff  <= '0;
         sat_ff  <= 1'b0;
         step_ff <= '0;
      end else if (do_step) begin
         num_ff  <= {num_ff[NW-2:0], 1'b0};
         rem_ff  <= qbit ? diff[29:0] : trial[29:0];
         quo_ff  <= {quo_ff[14:0], qbit};
         sat_ff  <= sat_ff | quo_ff[15];
         step_ff <= step_ff + CW'(1);
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_finish) begin
         rsp_emer_ff <= emer_flag_in;
         rsp_warn_ff <= warn_flag_in;
         rsp_load_ff <= load_q8;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_emergency_active = rsp_emer_ff;
   assign rsp_warning_active   = rsp_warn_ff;
   assign rsp_load_percent_q8  = rsp_load_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a raised flag always has a nonzero counter behind it
   a_emer_flag_cnt: assert property (@(posedge clock) disable iff (reset)
      emer_flag_ff |-> (emer_cnt_ff != 8'd0))
      else $error("emergency flag set with zero count");

   a_warn_flag_cnt: assert property (@(posedge clock) disable iff (reset)
      warn_flag_ff |-> (warn_cnt_ff != 8'd0))
      else $error("warning flag set with zero count");

   // an accepted word always starts a divider load
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      do_accept |=> (state_ff == ST_LOAD))
      else $error("accepted word did not start the divider");

   // a result only appears after the divider has run
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

endmodule
